/* design/grid_cell_neighbour_search_macros.svh */
// assertion macros of the grid cell neighbour search design, included by gcns_back
`ifndef GRID_CELL_NEIGHBOUR_SEARCH_MACROS_SVH
`define GRID_CELL_NEIGHBOUR_SEARCH_MACROS_SVH
`ifndef SYNTHESIS
`define GCNS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("gcns assertion failed");
`define GCNS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("gcns assertion failed");
`else
`define GCNS_ASSERT(lbl, clk, rst_n, prop)
`define GCNS_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

/* design/gcns_pkg.sv */
// types and constants of the grid cell neighbour search
package gcns_pkg;
    localparam int PART_MAX   = 64;
    localparam int PID_W      = $clog2(PART_MAX);
    localparam int CNT_W      = $clog2(PART_MAX + 1);
    localparam int SUBDIV_MAX = 16;
    localparam int IDX_W      = $clog2(SUBDIV_MAX);
    localparam int STEP_W     = $clog2(SUBDIV_MAX + 1);
    localparam int CELLS      = SUBDIV_MAX * SUBDIV_MAX;
    localparam int CELL_W     = $clog2(CELLS);
    localparam int MEMB_AW    = CELL_W + PID_W;
    localparam int COORD_W    = 16;
    localparam int DIVC_W     = $clog2(COORD_W);
    localparam int SUB_W      = 5;
    localparam int CFG_W      = 16;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [1:0] REG_SUBDIV = 2'd0;
    localparam logic [1:0] REG_CELL   = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;

    typedef struct packed {
        logic [SUB_W-1:0]   subdiv;
        logic [COORD_W-1:0] csize;
        logic [COORD_W-1:0] radius;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         op;
        logic [PID_W-1:0]   id;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [IDX_W-1:0]   ci;
        logic [IDX_W-1:0]   cj;
        logic [STEP_W-1:0]  step;
    } t_item;

    typedef struct packed {
        logic               start;
        logic [COORD_W-1:0] dividend;
        logic [COORD_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [COORD_W-1:0] quo;
        logic               rem_nz;
    } t_div_rsp;
endpackage

/* design/gcns_div.sv */
// iterative restoring divider, one quotient bit per cycle
module gcns_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gcns_pkg::t_div_req i_req,
    output gcns_pkg::t_div_rsp o_rsp
);
    import gcns_pkg::*;

    logic               r_busy;
    logic               r_done;
    logic [DIVC_W-1:0]  r_cnt;
    logic [COORD_W-1:0] r_quo;
    logic [COORD_W:0]   r_rem;
    logic [COORD_W-1:0] r_dvs;
    logic [COORD_W:0]   n_shift;
    logic               n_bit;
    logic [COORD_W:0]   n_rem;

    always_comb begin
        n_shift = {r_rem[COORD_W-1:0], r_quo[COORD_W-1]};
        n_bit   = (n_shift >= {1'b0, r_dvs});
        n_rem   = n_bit ? (n_shift - {1'b0, r_dvs}) : n_shift;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIVC_W'(COORD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[COORD_W-2:0], n_bit};
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.quo    = r_quo;
    assign o_rsp.rem_nz = |r_rem;
endmodule

/* design/gcns_front.sv */
// front end: accepts items and works out cell indices and search span
module gcns_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  gcns_pkg::t_cfg                 i_cfg,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [1:0]                     i_opcode,
    input  logic [gcns_pkg::PID_W-1:0]     i_particle_id,
    input  logic [gcns_pkg::COORD_W-1:0]   i_point_x,
    input  logic [gcns_pkg::COORD_W-1:0]   i_point_y,
    input  logic                           i_full,
    output logic                           o_push,
    output gcns_pkg::t_item                o_item
);
    import gcns_pkg::*;

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_DX   = 3'd1;
    localparam logic [2:0] F_DY   = 3'd2;
    localparam logic [2:0] F_DR   = 3'd3;
    localparam logic [2:0] F_PUSH = 3'd4;

    logic [2:0]         r_state;
    logic               r_start;
    t_item              r_item;
    t_div_req           w_req;
    t_div_rsp           w_rsp;
    logic [IDX_W-1:0]   w_idx;
    logic [STEP_W-1:0]  w_step;

    gcns_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_comb begin
        w_req.start    = r_start;
        w_req.divisor  = i_cfg.csize;
        case (r_state)
            F_DX:    w_req.dividend = r_item.x;
            F_DY:    w_req.dividend = r_item.y;
            F_DR:    w_req.dividend = i_cfg.radius;
            default: w_req.dividend = r_item.x;
        endcase
        // clamp to the last cell on or past the box edge
        if (w_rsp.quo >= COORD_W'(i_cfg.subdiv)) begin
            w_idx = IDX_W'(i_cfg.subdiv - 1'b1);
        end else begin
            w_idx = w_rsp.quo[IDX_W-1:0];
        end
        // ceiling of radius over cell size, saturated at the largest grid width (SUBDIV_MAX)
        if (w_rsp.quo >= COORD_W'(SUBDIV_MAX)) begin
            w_step = STEP_W'(SUBDIV_MAX);
        end else begin
            w_step = STEP_W'(w_rsp.quo) + STEP_W'(w_rsp.rem_nz);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_start <= 1'b0;
        end else begin
            r_start <= 1'b0;
            case (r_state)
                F_IDLE: begin
                    if (i_in_valid) begin
                        if (i_opcode == OP_INSERT || i_opcode == OP_QUERY) begin
                            r_state <= F_DX;
                            r_start <= 1'b1;
                        end else begin
                            r_state <= F_PUSH;
                        end
                    end
                end
                F_DX: begin
                    if (w_rsp.done) begin
                        r_state <= F_DY;
                        r_start <= 1'b1;
                    end
                end
                F_DY: begin
                    if (w_rsp.done) begin
                        if (r_item.op == OP_QUERY) begin
                            r_state <= F_DR;
                            r_start <= 1'b1;
                        end else begin
                            r_state <= F_PUSH;
                        end
                    end
                end
                F_DR: begin
                    if (w_rsp.done) begin
                        r_state <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_in_valid) begin
            r_item.op   <= i_opcode;
            r_item.id   <= i_particle_id;
            r_item.x    <= i_point_x;
            r_item.y    <= i_point_y;
            r_item.ci   <= '0;
            r_item.cj   <= '0;
            r_item.step <= '0;
        end else if (w_rsp.done) begin
            if (r_state == F_DX) r_item.ci <= w_idx;
            if (r_state == F_DY) r_item.cj <= w_idx;
            if (r_state == F_DR) r_item.step <= w_step;
        end
    end

    assign o_in_ready = (r_state == F_IDLE);
    assign o_push     = (r_state == F_PUSH) && !i_full;
    assign o_item     = r_item;
endmodule

/* design/gcns_fifo.sv */
// two-entry queue between front and back
module gcns_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  gcns_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output gcns_pkg::t_item o_item
);
    import gcns_pkg::*;

    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_item;
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_item  = r_mem[r_rp];
endmodule

/* design/gcns_back.sv */
// back end: cell lists, position store, query walk and result register
`include "grid_cell_neighbour_search_macros.svh"
module gcns_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  gcns_pkg::t_cfg               i_cfg,
    input  logic                         i_empty,
    input  gcns_pkg::t_item              i_item,
    output logic                         o_pop,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [gcns_pkg::PID_W-1:0]   o_neighbour_id,
    output logic                         o_found,
    output logic                         o_is_last
);
    import gcns_pkg::*;

    localparam logic [3:0] B_IDLE    = 4'd0;
    localparam logic [3:0] B_INS_RD  = 4'd1;
    localparam logic [3:0] B_INS_WR  = 4'd2;
    localparam logic [3:0] B_Q_SETUP = 4'd3;
    localparam logic [3:0] B_Q_CELL  = 4'd4;
    localparam logic [3:0] B_Q_CNT   = 4'd5;
    localparam logic [3:0] B_Q_MID   = 4'd6;
    localparam logic [3:0] B_Q_POS   = 4'd7;
    localparam logic [3:0] B_Q_SQ    = 4'd8;
    localparam logic [3:0] B_Q_MRD   = 4'd9;
    localparam logic [3:0] B_Q_END   = 4'd10;

    logic [CNT_W-1:0]     cnt_mem  [CELLS];
    logic [PID_W-1:0]     memb_mem [CELLS * PART_MAX];
    logic [2*COORD_W-1:0] pos_mem  [PART_MAX];

    logic [3:0]           r_state;
    logic [CELLS-1:0]     r_cvld;
    logic [CNT_W-1:0]     r_total;
    logic [PID_W-1:0]     r_id;
    logic [COORD_W-1:0]   r_qx;
    logic [COORD_W-1:0]   r_qy;
    logic [IDX_W-1:0]     r_ci;
    logic [IDX_W-1:0]     r_cj;
    logic [STEP_W-1:0]    r_step;
    logic [IDX_W-1:0]     r_i;
    logic [IDX_W-1:0]     r_j;
    logic [IDX_W-1:0]     r_ihi;
    logic [IDX_W-1:0]     r_jlo;
    logic [IDX_W-1:0]     r_jhi;
    logic [CNT_W-1:0]     r_k;
    logic [CNT_W-1:0]     r_num;
    logic [2*COORD_W-1:0] r_r2;
    logic [2*COORD_W-1:0] r_dx2;
    logic [2*COORD_W-1:0] r_dy2;
    logic [CNT_W-1:0]     r_cnt_rd;
    logic                 r_cvld_rd;
    logic [PID_W-1:0]     r_memb_rd;
    logic [2*COORD_W-1:0] r_pos_rd;
    logic [PID_W-1:0]     r_pid;
    logic                 r_pend_v;
    logic [PID_W-1:0]     r_pend_id;
    logic                 r_out_v;
    logic [PID_W-1:0]     r_out_id;
    logic                 r_out_found;
    logic                 r_out_last;

    logic [CELL_W-1:0]    w_cell;
    logic [CNT_W-1:0]     w_num;
    logic [MEMB_AW-1:0]   w_memb_addr;
    logic                 w_ins_we;
    logic [COORD_W-1:0]   w_px;
    logic [COORD_W-1:0]   w_py;
    logic [COORD_W-1:0]   w_dx;
    logic [COORD_W-1:0]   w_dy;
    logic                 w_hit;
    logic                 w_last_cell;
    logic [SUB_W:0]       w_lo_diff_i;
    logic [SUB_W:0]       w_lo_diff_j;
    logic [SUB_W:0]       w_hi_sum_i;
    logic [SUB_W:0]       w_hi_sum_j;

    always_comb begin
        w_cell      = CELL_W'(r_i) + CELL_W'(r_j) * CELL_W'(i_cfg.subdiv);
        w_num       = r_cvld_rd ? r_cnt_rd : '0;
        w_ins_we    = (r_state == B_INS_WR);
        w_memb_addr = w_ins_we ? {w_cell, w_num[PID_W-1:0]} : {w_cell, r_k[PID_W-1:0]};
        w_px        = r_pos_rd[2*COORD_W-1:COORD_W];
        w_py        = r_pos_rd[COORD_W-1:0];
        w_dx        = (w_px >= r_qx) ? (w_px - r_qx) : (r_qx - w_px);
        w_dy        = (w_py >= r_qy) ? (w_py - r_qy) : (r_qy - w_py);
        w_hit       = ({1'b0, r_dx2} + {1'b0, r_dy2}) <= {1'b0, r_r2};
        w_last_cell = (r_i == r_ihi) && (r_j == r_jhi);
        w_lo_diff_i = (SUB_W + 1)'(r_ci) - (SUB_W + 1)'(r_step);
        w_lo_diff_j = (SUB_W + 1)'(r_cj) - (SUB_W + 1)'(r_step);
        w_hi_sum_i  = (SUB_W + 1)'(r_ci) + (SUB_W + 1)'(r_step);
        w_hi_sum_j  = (SUB_W + 1)'(r_cj) + (SUB_W + 1)'(r_step);
    end

    // memories: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (w_ins_we) cnt_mem[w_cell] <= w_num + 1'b1;
        r_cnt_rd <= cnt_mem[w_cell];
    end

    always_ff @(posedge i_clk) begin
        if (w_ins_we) memb_mem[w_memb_addr] <= r_id;
        r_memb_rd <= memb_mem[w_memb_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_ins_we) pos_mem[r_id] <= {r_qx, r_qy};
        r_pos_rd <= pos_mem[r_memb_rd];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_cvld   <= '0;
            r_total  <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (r_out_v && i_out_ready) r_out_v <= 1'b0;
            case (r_state)
                B_IDLE: begin
                    if (!i_empty) begin
                        case (i_item.op)
                            OP_CLEAR: begin
                                r_cvld  <= '0;
                                r_total <= '0;
                            end
                            OP_INSERT: begin
                                if (r_total < CNT_W'(PART_MAX)) r_state <= B_INS_RD;
                            end
                            OP_QUERY: r_state <= B_Q_SETUP;
                            default: r_state <= B_IDLE;
                        endcase
                    end
                end
                B_INS_RD: r_state <= B_INS_WR;
                B_INS_WR: begin
                    r_cvld[w_cell] <= 1'b1;
                    r_total        <= r_total + 1'b1;
                    r_state        <= B_IDLE;
                end
                B_Q_SETUP: r_state <= B_Q_CELL;
                B_Q_CELL:  r_state <= B_Q_CNT;
                B_Q_CNT: begin
                    if (w_num != '0)      r_state <= B_Q_MID;
                    else if (w_last_cell) r_state <= B_Q_END;
                    else                  r_state <= B_Q_CELL;
                end
                B_Q_MID: r_state <= B_Q_POS;
                B_Q_POS: r_state <= B_Q_SQ;
                B_Q_SQ: begin
                    if (!(w_hit && r_pend_v && r_out_v)) begin
                        if (w_hit) begin
                            r_pend_v <= 1'b1;
                            if (r_pend_v) r_out_v <= 1'b1;
                        end
                        if (r_k + 1'b1 < r_num) r_state <= B_Q_MRD;
                        else if (w_last_cell)   r_state <= B_Q_END;
                        else                    r_state <= B_Q_CELL;
                    end
                end
                B_Q_MRD: r_state <= B_Q_MID;
                B_Q_END: begin
                    if (!r_out_v) begin
                        r_out_v  <= 1'b1;
                        r_pend_v <= 1'b0;
                        r_state  <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    // datapath registers of the walk
    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_id   <= i_item.id;
                r_qx   <= i_item.x;
                r_qy   <= i_item.y;
                r_ci   <= i_item.ci;
                r_cj   <= i_item.cj;
                r_step <= i_item.step;
                r_i    <= i_item.ci;
                r_j    <= i_item.cj;
            end
            B_Q_SETUP: begin
                r_i   <= ((SUB_W + 1)'(r_ci) > (SUB_W + 1)'(r_step))
                         ? w_lo_diff_i[IDX_W-1:0] : '0;
                r_j   <= ((SUB_W + 1)'(r_cj) > (SUB_W + 1)'(r_step))
                         ? w_lo_diff_j[IDX_W-1:0] : '0;
                r_jlo <= ((SUB_W + 1)'(r_cj) > (SUB_W + 1)'(r_step))
                         ? w_lo_diff_j[IDX_W-1:0] : '0;
                r_ihi <= (w_hi_sum_i >= (SUB_W + 1)'(i_cfg.subdiv))
                         ? IDX_W'(i_cfg.subdiv - 1'b1) : w_hi_sum_i[IDX_W-1:0];
                r_jhi <= (w_hi_sum_j >= (SUB_W + 1)'(i_cfg.subdiv))
                         ? IDX_W'(i_cfg.subdiv - 1'b1) : w_hi_sum_j[IDX_W-1:0];
                r_r2  <= i_cfg.radius * i_cfg.radius;
            end
            B_Q_CELL: r_k <= '0;
            B_Q_CNT: begin
                r_num <= w_num;
                if (w_num == '0 && !w_last_cell) begin
                    if (r_j == r_jhi) begin
                        r_i <= r_i + 1'b1;
                        r_j <= r_jlo;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
            end
            B_Q_MID: r_pid <= r_memb_rd;
            B_Q_POS: begin
                r_dx2 <= w_dx * w_dx;
                r_dy2 <= w_dy * w_dy;
            end
            B_Q_SQ: begin
                if (!(w_hit && r_pend_v && r_out_v)) begin
                    if (w_hit) begin
                        r_pend_id <= r_pid;
                        if (r_pend_v) begin
                            r_out_id    <= r_pend_id;
                            r_out_found <= 1'b1;
                            r_out_last  <= 1'b0;
                        end
                    end
                    if (r_k + 1'b1 < r_num) begin
                        r_k <= r_k + 1'b1;
                    end else if (!w_last_cell) begin
                        if (r_j == r_jhi) begin
                            r_i <= r_i + 1'b1;
                            r_j <= r_jlo;
                        end else begin
                            r_j <= r_j + 1'b1;
                        end
                    end
                end
            end
            B_Q_END: begin
                if (!r_out_v) begin
                    r_out_id    <= r_pend_v ? r_pend_id : '0;
                    r_out_found <= r_pend_v;
                    r_out_last  <= 1'b1;
                end
            end
            default: r_k <= r_k;
        endcase
        r_cvld_rd <= r_cvld[w_cell];
    end

    assign o_pop          = (r_state == B_IDLE) && !i_empty;
    assign o_out_valid    = r_out_v;
    assign o_neighbour_id = r_out_id;
    assign o_found        = r_out_found;
    assign o_is_last      = r_out_last;

    `GCNS_ASSERT(a_total_cap, i_clk, i_rst_n, r_total <= CNT_W'(PART_MAX))
    `GCNS_ASSERT(a_pend_in_query, i_clk, i_rst_n, r_pend_v |-> (r_state >= B_Q_SETUP))
    `GCNS_ASSERT(a_walk_in_span, i_clk, i_rst_n, (r_state == B_Q_CNT) |-> (r_i <= r_ihi && r_j <= r_jhi))
    `GCNS_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> (r_state == B_IDLE && !r_out_v))
endmodule

/* design/grid_cell_neighbour_search.sv */
// top level of the grid cell neighbour search: config registers, front, queue, back
// insert runs two bit-serial divisions in the front (x, y), query three (x, y, radius); a
// query then walks every cell of its span and every list entry, and stalls on the output
// front and back overlap through a two-entry queue
// reset: synchronous active low; cell counts read as zero through per-cell valid bits
// so no clearing pass is needed, config returns to 10 cells per axis of size 256, radius 0
module grid_cell_neighbour_search (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [1:0]                   i_cfg_index,
    input  logic [gcns_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_opcode,
    input  logic [gcns_pkg::PID_W-1:0]   i_particle_id,
    input  logic [gcns_pkg::COORD_W-1:0] i_point_x,
    input  logic [gcns_pkg::COORD_W-1:0] i_point_y,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [gcns_pkg::PID_W-1:0]   o_neighbour_id,
    output logic                         o_found,
    output logic                         o_is_last
);
    import gcns_pkg::*;

    // raw register values as written
    logic [SUB_W-1:0]   r_subdiv;
    logic [COORD_W-1:0] r_cell;
    logic [COORD_W-1:0] r_radius;

    // effective config seen by both halves
    t_cfg  w_cfg;
    t_item w_push_item;
    t_item w_pop_item;
    logic  w_push;
    logic  w_full;
    logic  w_pop;
    logic  w_empty;

    // config transactions are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_subdiv <= SUB_W'(10);
            r_cell   <= COORD_W'(256);
            r_radius <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SUBDIV: r_subdiv <= i_cfg_data[SUB_W-1:0];
                REG_CELL:   r_cell   <= i_cfg_data[COORD_W-1:0];
                REG_RADIUS: r_radius <= i_cfg_data[COORD_W-1:0];
                default:    r_radius <= r_radius;
            endcase
        end
    end

    // out-of-range subdivision saturates, zero cell size acts as the smallest step
    always_comb begin
        if (r_subdiv == '0) begin
            w_cfg.subdiv = SUB_W'(1);
        end else if (r_subdiv > SUB_W'(SUBDIV_MAX)) begin
            w_cfg.subdiv = SUB_W'(SUBDIV_MAX);
        end else begin
            w_cfg.subdiv = r_subdiv;
        end
        w_cfg.csize  = (r_cell == '0) ? COORD_W'(1) : r_cell;
        w_cfg.radius = r_radius;
    end

    // front: takes a transaction, divides out the cell indices and search step
    gcns_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_particle_id (i_particle_id),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_full        (w_full),
        .o_push        (w_push),
        .o_item        (w_push_item)
    );

    // short queue so front and back stall independently
    gcns_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_item  (w_pop_item)
    );

    // back: updates cell lists, walks the neighborhood, holds the result register
    gcns_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_empty        (w_empty),
        .i_item         (w_pop_item),
        .o_pop          (w_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_neighbour_id (o_neighbour_id),
        .o_found        (o_found),
        .o_is_last      (o_is_last)
    );
endmodule
